[design/xalu_pkg.sv]
// Shared types, codes and helper functions for the x86 ADD/ADC/AND and BCD adjust ALU.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package xalu_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FLAG_N  = 6;

    // operation codes
    typedef logic [2:0] t_op;
    localparam t_op OP_ADD = 3'd0;
    localparam t_op OP_ADC = 3'd1;
    localparam t_op OP_AND = 3'd2;
    localparam t_op OP_AAA = 3'd3;
    localparam t_op OP_AAS = 3'd4;
    localparam t_op OP_AAD = 3'd5;
    localparam t_op OP_AAM = 3'd6;

    // operand size codes; the unused code behaves as 32-bit
    typedef logic [1:0] t_size;
    localparam t_size SIZE_8  = 2'd0;
    localparam t_size SIZE_16 = 2'd1;
    localparam t_size SIZE_32 = 2'd2;

    // flag positions in the written mask
    localparam int unsigned FLAG_CF = 0;
    localparam int unsigned FLAG_PF = 1;
    localparam int unsigned FLAG_AF = 2;
    localparam int unsigned FLAG_ZF = 3;
    localparam int unsigned FLAG_SF = 4;
    localparam int unsigned FLAG_OF = 5;

    typedef logic [FLAG_N-1:0] t_flags;
    localparam t_flags FW_NONE  = 6'b000000;
    localparam t_flags FW_ALL   = 6'b111111;
    localparam t_flags FW_AND   = 6'b111011;   // all but AF
    localparam t_flags FW_ADJ   = 6'b000101;   // CF, AF
    localparam t_flags FW_SZP   = 6'b011010;   // PF, ZF, SF

    // BCD adjust constants
    localparam logic [7:0] BCD_ADJ       = 8'h06;
    localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;
    localparam logic [7:0] BCD_AH_STEP   = 8'h01;

    typedef struct packed {
        logic pf;
        logic zf;
        logic sf;
    } t_szp;

    // one pipeline stage's payload
    typedef struct packed {
        t_op               op;
        t_size             size;      // size for flag evaluation
        logic [DATA_W-1:0] res;
        logic              cf;
        logic              af;
        logic              of;
        logic              de;
        t_flags            fw;
        logic [BYTE_W-1:0] dvd;       // AAM dividend (AL)
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] rem;       // AAM partial remainder
        logic [BYTE_W-1:0] quo;       // AAM quotient, filled MSB first
    } t_stage;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              cf;
        logic              pf;
        logic              af;
        logic              zf;
        logic              sf;
        logic              of;
        t_flags            fw;
        logic              de;
    } t_result;

    function automatic logic [DATA_W-1:0] size_mask(input t_size s);
        logic [DATA_W-1:0] m;
        unique case (s)
            SIZE_8:  m = 32'h0000_00FF;
            SIZE_16: m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic size_msb(input logic [DATA_W-1:0] v, input t_size s);
        logic b;
        unique case (s)
            SIZE_8:  b = v[7];
            SIZE_16: b = v[15];
            default: b = v[31];
        endcase
        return b;
    endfunction

    // one restoring-divide step: returns {quotient bit, new remainder}
    function automatic logic [BYTE_W:0] aam_div_step(input logic [BYTE_W-1:0] rem,
                                                     input logic dbit,
                                                     input logic [BYTE_W-1:0] base);
        logic [BYTE_W:0] trial;
        logic [BYTE_W:0] diff;
        trial = {rem, dbit};
        diff  = trial - {1'b0, base};
        if (trial >= {1'b0, base}) begin
            return {1'b1, diff[BYTE_W-1:0]};
        end else begin
            return {1'b0, trial[BYTE_W-1:0]};
        end
    endfunction

endpackage

`default_nettype wire

[design/xalu_in_if.sv]
// Input channel of the ALU: valid/ready handshake plus one operation beat.
// Depends on xalu_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

interface xalu_in_if;
    logic                 valid;
    logic                 ready;
    xalu_pkg::t_op        op;
    xalu_pkg::t_size      width;
    logic [31:0]          operand_a;
    logic [31:0]          operand_b;
    logic [7:0]           base;
    logic                 carry_in;
    logic                 aux_in;

    modport source (
        output valid, op, width, operand_a, operand_b, base, carry_in, aux_in,
        input  ready
    );
    modport sink (
        input  valid, op, width, operand_a, operand_b, base, carry_in, aux_in,
        output ready
    );
endinterface

`default_nettype wire

[design/xalu_out_if.sv]
// Output channel of the ALU: valid/ready handshake plus one result beat.
// Depends on xalu_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

interface xalu_out_if;
    logic                 valid;
    logic                 ready;
    logic [31:0]          result;
    logic                 carry_out;
    logic                 parity_out;
    logic                 aux_out;
    logic                 zero_out;
    logic                 sign_out;
    logic                 overflow_out;
    xalu_pkg::t_flags     flags_written;
    logic                 divide_error;

    modport source (
        output valid, result, carry_out, parity_out, aux_out, zero_out, sign_out,
               overflow_out, flags_written, divide_error,
        input  ready
    );
    modport sink (
        input  valid, result, carry_out, parity_out, aux_out, zero_out, sign_out,
               overflow_out, flags_written, divide_error,
        output ready
    );
endinterface

`default_nettype wire

[design/x86_alu_add_and_bcd_flags.sv]
// x86 ALU slice: ADD, ADC, AND (8/16/32-bit) and the BCD adjusts AAA, AAS, AAD, AAM, with the
// six arithmetic flags, a written-flag mask and the AAM divide error. Fully pipelined: three
// register stages, one beat accepted per clock while the output side is not stalled. Stage 1
// does the 32-bit add, the logic op, the BCD adjusts, the AAD 8x8 multiply and the first
// three bits of the AAM divide; stage 2 does three more divide bits; stage 3 finishes the
// last two, evaluates PF/ZF/SF and is the output register. The AAM divide is a restoring
// divider spread over the stages, so its depth sets the stage count. A stall on the output
// holds only full stages: empty stages keep filling, and input ready drops only when all
// three stages hold beats and the output is stalled. Flags outside the written mask read as
// zero; opcode seven yields an all-zero beat.
// Depends on xalu_pkg, xalu_in_if, xalu_out_if and xalu_flag_gen.
`timescale 1ns / 1ps
`default_nettype none

module x86_alu_add_and_bcd_flags (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    xalu_in_if.sink     i_in,
    xalu_out_if.source  o_out
);

    // ---------------------------------------------------------------- pipeline control
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;

    // a stage advances when it is empty or the one after it advances
    assign adv3       = !r_v3 || o_out.ready;
    assign adv2       = !r_v2 || adv3;
    assign adv1       = !r_v1 || adv2;
    assign i_in.ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in.valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // ---------------------------------------------------------------- stage 1
    xalu_pkg::t_stage          n_s1, r_s1;
    logic [31:0]               mask;
    logic [31:0]               a_m, b_m, sum_r;
    logic [32:0]               sum;
    logic                      cin, add_cf;
    logic [7:0]                al, ah, al_adj, ah_adj, aad_al;
    logic [15:0]               aad_prod;
    logic                      adj;
    logic [8:0]                d7, d6, d5;

    assign mask     = xalu_pkg::size_mask(i_in.width);
    assign a_m      = i_in.operand_a & mask;
    assign b_m      = i_in.operand_b & mask;
    assign cin      = (i_in.op == xalu_pkg::OP_ADC) && i_in.carry_in;
    assign sum      = {1'b0, a_m} + {1'b0, b_m} + {32'd0, cin};
    assign sum_r    = sum[31:0] & mask;

    always_comb begin
        unique case (i_in.width)
            xalu_pkg::SIZE_8:  add_cf = sum[8];
            xalu_pkg::SIZE_16: add_cf = sum[16];
            default:           add_cf = sum[32];
        endcase
    end

    assign al       = i_in.operand_a[7:0];
    assign ah       = i_in.operand_b[7:0];
    // adjust when the low digit is out of BCD range or AF came in set
    assign adj      = (al[3:0] > xalu_pkg::BCD_DIGIT_MAX) || i_in.aux_in;
    assign al_adj   = (i_in.op == xalu_pkg::OP_AAA) ? al + xalu_pkg::BCD_ADJ
                                                    : al - xalu_pkg::BCD_ADJ;
    assign ah_adj   = (i_in.op == xalu_pkg::OP_AAA) ? ah + xalu_pkg::BCD_AH_STEP
                                                    : ah - xalu_pkg::BCD_AH_STEP;
    assign aad_prod = ah * i_in.base;
    assign aad_al   = al + aad_prod[7:0];

    // AAM quotient bits 7..5
    assign d7 = xalu_pkg::aam_div_step(8'd0,     al[7], i_in.base);
    assign d6 = xalu_pkg::aam_div_step(d7[7:0],  al[6], i_in.base);
    assign d5 = xalu_pkg::aam_div_step(d6[7:0],  al[5], i_in.base);

    always_comb begin
        n_s1      = '0;
        n_s1.op   = i_in.op;
        n_s1.size = xalu_pkg::SIZE_8;       // BCD flags are taken over AL
        n_s1.dvd  = al;
        n_s1.base = i_in.base;
        n_s1.rem  = d5[7:0];
        n_s1.quo  = {d7[8], d6[8], d5[8], 5'd0};
        unique case (i_in.op)
            xalu_pkg::OP_ADD, xalu_pkg::OP_ADC: begin
                n_s1.size = i_in.width;
                n_s1.res  = sum_r;
                n_s1.cf   = add_cf;
                n_s1.of   = xalu_pkg::size_msb((i_in.operand_a ^ sum_r)
                                               & (i_in.operand_b ^ sum_r), i_in.width);
                n_s1.af   = (i_in.operand_a[4] ^ i_in.operand_b[4] ^ sum_r[4]);
                n_s1.fw   = xalu_pkg::FW_ALL;
            end
            xalu_pkg::OP_AND: begin
                n_s1.size = i_in.width;
                n_s1.res  = i_in.operand_a & i_in.operand_b & mask;
                n_s1.fw   = xalu_pkg::FW_AND;
            end
            xalu_pkg::OP_AAA, xalu_pkg::OP_AAS: begin
                if (adj) begin
                    n_s1.res = {16'd0, ah_adj, 4'd0, al_adj[3:0]};
                    n_s1.cf  = 1'b1;
                    n_s1.af  = 1'b1;
                end else begin
                    n_s1.res = {16'd0, ah, 4'd0, al[3:0]};
                end
                n_s1.fw = xalu_pkg::FW_ADJ;
            end
            xalu_pkg::OP_AAD: begin
                n_s1.res = {24'd0, aad_al};
                n_s1.fw  = xalu_pkg::FW_SZP;
            end
            xalu_pkg::OP_AAM: begin
                n_s1.de = (i_in.base == 8'd0);
                n_s1.fw = (i_in.base == 8'd0) ? xalu_pkg::FW_NONE : xalu_pkg::FW_SZP;
            end
            default: begin
                // no operation: all-zero beat
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv1) r_s1 <= n_s1;
    end

    // ---------------------------------------------------------------- stage 2
    xalu_pkg::t_stage n_s2, r_s2;
    logic [8:0]       d4, d3, d2;

    // AAM quotient bits 4..2
    assign d4 = xalu_pkg::aam_div_step(r_s1.rem, r_s1.dvd[4], r_s1.base);
    assign d3 = xalu_pkg::aam_div_step(d4[7:0],  r_s1.dvd[3], r_s1.base);
    assign d2 = xalu_pkg::aam_div_step(d3[7:0],  r_s1.dvd[2], r_s1.base);

    always_comb begin
        n_s2          = r_s1;
        n_s2.rem      = d2[7:0];
        n_s2.quo[4:2] = {d4[8], d3[8], d2[8]};
    end

    always_ff @(posedge i_clk) begin
        if (adv2) r_s2 <= n_s2;
    end

    // ---------------------------------------------------------------- stage 3
    xalu_pkg::t_result n_s3, r_s3;
    logic [8:0]        d1, d0;
    logic [7:0]        quo_f;
    logic              is_aam;
    logic [31:0]       flag_val;
    xalu_pkg::t_szp    szp;

    // AAM quotient bits 1..0
    assign d1     = xalu_pkg::aam_div_step(r_s2.rem, r_s2.dvd[1], r_s2.base);
    assign d0     = xalu_pkg::aam_div_step(d1[7:0],  r_s2.dvd[0], r_s2.base);
    assign quo_f  = {r_s2.quo[7:2], d1[8], d0[8]};
    assign is_aam = (r_s2.op == xalu_pkg::OP_AAM) && !r_s2.de;

    // AAM flags come from the new AL (the remainder)
    assign flag_val = is_aam ? {24'd0, d0[7:0]} : r_s2.res;

    xalu_flag_gen u_flag_gen (
        .i_value (flag_val),
        .i_size  (r_s2.size),
        .o_szp   (szp)
    );

    always_comb begin
        n_s3.result = is_aam ? {16'd0, quo_f, d0[7:0]} : r_s2.res;
        n_s3.cf     = r_s2.cf & r_s2.fw[xalu_pkg::FLAG_CF];
        n_s3.pf     = szp.pf  & r_s2.fw[xalu_pkg::FLAG_PF];
        n_s3.af     = r_s2.af & r_s2.fw[xalu_pkg::FLAG_AF];
        n_s3.zf     = szp.zf  & r_s2.fw[xalu_pkg::FLAG_ZF];
        n_s3.sf     = szp.sf  & r_s2.fw[xalu_pkg::FLAG_SF];
        n_s3.of     = r_s2.of & r_s2.fw[xalu_pkg::FLAG_OF];
        n_s3.fw     = r_s2.fw;
        n_s3.de     = r_s2.de;
    end

    always_ff @(posedge i_clk) begin
        if (adv3) r_s3 <= n_s3;
    end

    // ---------------------------------------------------------------- output beat
    assign o_out.valid         = r_v3;
    assign o_out.result        = r_s3.result;
    assign o_out.carry_out     = r_s3.cf;
    assign o_out.parity_out    = r_s3.pf;
    assign o_out.aux_out       = r_s3.af;
    assign o_out.zero_out      = r_s3.zf;
    assign o_out.sign_out      = r_s3.sf;
    assign o_out.overflow_out  = r_s3.of;
    assign o_out.flags_written = r_s3.fw;
    assign o_out.divide_error  = r_s3.de;

endmodule

`default_nettype wire

[design/xalu_flag_gen.sv]
// Sign, zero and parity flag generation over a result at a given operand size.
// Depends on xalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xalu_flag_gen (
    input  wire logic [xalu_pkg::DATA_W-1:0] i_value,
    input  wire xalu_pkg::t_size             i_size,
    output xalu_pkg::t_szp                   o_szp
);

    logic [xalu_pkg::DATA_W-1:0] masked;

    assign masked   = i_value & xalu_pkg::size_mask(i_size);
    assign o_szp.zf = (masked == '0);
    assign o_szp.sf = xalu_pkg::size_msb(masked, i_size);
    assign o_szp.pf = ~^masked[xalu_pkg::BYTE_W-1:0];   // even parity of low byte

endmodule

`default_nettype wire

[design/xalu_checker.sv]
// Port-level assertions for the ALU pipeline, attached to the top level by bind.
// Depends on xalu_pkg and x86_alu_add_and_bcd_flags.
`timescale 1ns / 1ps
`default_nettype none

module xalu_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [31:0]       i_result,
    input wire logic              i_carry_out,
    input wire logic              i_parity_out,
    input wire logic              i_aux_out,
    input wire logic              i_zero_out,
    input wire logic              i_sign_out,
    input wire logic              i_overflow_out,
    input wire xalu_pkg::t_flags  i_flags_written,
    input wire logic              i_divide_error
);

    // a stalled output beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_result) && $stable(i_flags_written))
        else $error("output beat changed while stalled");

    // with an empty output register every stage can move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

    // unwritten flags read as zero
    a_flags_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (!i_carry_out    || i_flags_written[xalu_pkg::FLAG_CF]) &&
            (!i_parity_out   || i_flags_written[xalu_pkg::FLAG_PF]) &&
            (!i_aux_out      || i_flags_written[xalu_pkg::FLAG_AF]) &&
            (!i_zero_out     || i_flags_written[xalu_pkg::FLAG_ZF]) &&
            (!i_sign_out     || i_flags_written[xalu_pkg::FLAG_SF]) &&
            (!i_overflow_out || i_flags_written[xalu_pkg::FLAG_OF]))
        else $error("flag set outside written mask");

    // a divide error carries no result and no flags
    a_div_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_divide_error |->
            (i_result == 32'd0) && (i_flags_written == xalu_pkg::FW_NONE))
        else $error("divide error beat carries data");

endmodule

bind x86_alu_add_and_bcd_flags xalu_checker u_xalu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_result        (o_out.result),
    .i_carry_out     (o_out.carry_out),
    .i_parity_out    (o_out.parity_out),
    .i_aux_out       (o_out.aux_out),
    .i_zero_out      (o_out.zero_out),
    .i_sign_out      (o_out.sign_out),
    .i_overflow_out  (o_out.overflow_out),
    .i_flags_written (o_out.flags_written),
    .i_divide_error  (o_out.divide_error)
);

`default_nettype wire
